// ===== hdl/i2cbb_pkg.sv =====
package i2cbb_pkg;

    // command codes; idle is code seven, code six is spare
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_SACK  = 3'd4;
    localparam logic [2:0] CMD_RACK  = 3'd5;
    localparam logic [2:0] CMD_SPARE = 3'd6;
    localparam logic [2:0] CMD_IDLE  = 3'd7;

    localparam logic [1:0] SUB_LAST  = 2'd2;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } t_res_word;

    // number of phases of each command
    function automatic logic [4:0] seq_len(input logic [2:0] cmd);
        logic [4:0] len;
        case (cmd)
            CMD_START: len = 5'd4;
            CMD_STOP:  len = 5'd3;
            CMD_WRITE: len = 5'd24;
            CMD_READ:  len = 5'd25;
            CMD_SACK:  len = 5'd3;
            default:   len = 5'd4;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/i2cbb_if.sv =====
interface i2cbb_in_if;
    import i2cbb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cbb_res_if;
    import i2cbb_pkg::*;
    logic      valid;
    logic      ready;
    t_res_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/i2c_bitbang_master_phy_top.sv =====
// channel | dir | handshake          | payload
// i_cmd   | in  | valid/ready        | cmd_valid, mode, tx_byte, ack_out, sda_in
// o_res   | out | valid/ready        | scl_out, sda_out, busy_res, done_res, rx_byte, ack_in
//
// One word in, one word out; a word can be taken every cycle while o_res accepts results, and its
// result appears in the cycle after, from the result register behind the phase sequencer.
// Reset (i_rst_n low, synchronous) leaves the sequencer idle with both lines released high.
// While a result waits unaccepted, i_cmd.ready drops unless o_res.ready is high in that cycle.
module i2c_bitbang_master_phy_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbb_in_if.sink    i_cmd,
    i2cbb_res_if.source o_res
);
    import i2cbb_pkg::*;

    logic      r_out_valid;
    t_res_word r_out_word;
    t_res_word n_out_word;
    logic      step;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign step        = i_cmd.valid && i_cmd.ready;

    i2cbb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (i_cmd.data),
        .o_next  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_word;

endmodule

// ===== hdl/i2cbb_core.sv =====
module i2cbb_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  i2cbb_pkg::t_in_word   i_word,
    output i2cbb_pkg::t_res_word  o_next
);
    import i2cbb_pkg::*;

    logic [2:0] r_cmd, n_cmd;
    logic [4:0] r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_ack_hold, n_ack_hold;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx, n_rx;
    logic       r_ack_seen, n_ack_seen;
    logic       n_done;

    always_comb begin
        logic [2:0] bit_sel;
        n_cmd      = r_cmd;
        n_phase    = r_phase;
        n_sub      = r_sub;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_ack_hold = r_ack_hold;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_rx       = r_rx;
        n_ack_seen = r_ack_seen;
        n_done     = 1'b0;
        bit_sel    = 3'd7 - r_bit;

        // take a new command only when idle
        if (r_cmd == CMD_IDLE && i_word.cmd_valid && (i_word.mode inside {[CMD_START:CMD_RACK]}))
        begin
            n_cmd   = i_word.mode;
            n_phase = 5'd0;
            n_sub   = 2'd0;
            n_bit   = 3'd0;
            bit_sel = 3'd7;
            if (i_word.mode == CMD_WRITE) begin
                n_shift = i_word.tx_byte;
            end else if (i_word.mode == CMD_READ) begin
                n_shift = 8'd0;
            end else if (i_word.mode == CMD_SACK) begin
                n_ack_hold = i_word.ack_out;
            end
        end

        if (n_cmd != CMD_IDLE) begin
            case (n_cmd)
                CMD_START: begin
                    case (n_phase)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (n_phase)
                        5'd0:    n_sda = 1'b0;
                        5'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    case (n_sub)
                        2'd0:    n_sda = n_shift[bit_sel];
                        2'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_READ: begin
                    if (n_phase == 5'd0) begin
                        n_sda = 1'b1;
                    end else begin
                        case (n_sub)
                            2'd0:    n_scl = 1'b1;
                            2'd1:    n_shift[bit_sel] = n_shift[bit_sel] | i_word.sda_in;
                            default: n_scl = 1'b0;
                        endcase
                    end
                end
                CMD_SACK: begin
                    case (n_phase)
                        5'd0:    n_sda = n_ack_hold;
                        5'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                default: begin
                    case (n_phase)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_ack_seen = i_word.sda_in;
                        default: n_scl = 1'b0;
                    endcase
                end
            endcase

            // the release phase of a read does not count as a bit slot
            if (!(n_cmd == CMD_READ && n_phase == 5'd0)) begin
                if (n_sub == SUB_LAST) begin
                    n_sub = 2'd0;
                    n_bit = n_bit + 3'd1;
                end else begin
                    n_sub = n_sub + 2'd1;
                end
            end

            n_phase = n_phase + 5'd1;
            if (n_phase >= seq_len(n_cmd)) begin
                if (n_cmd == CMD_READ) begin
                    n_rx = n_shift;
                end
                n_cmd   = CMD_IDLE;
                n_phase = 5'd0;
                n_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= CMD_IDLE;
            r_phase    <= 5'd0;
            r_sub      <= 2'd0;
            r_bit      <= 3'd0;
            r_shift    <= 8'd0;
            r_ack_hold <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_rx       <= 8'd0;
            r_ack_seen <= 1'b0;
        end else if (i_step) begin
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_sub      <= n_sub;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_ack_hold <= n_ack_hold;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_rx       <= n_rx;
            r_ack_seen <= n_ack_seen;
        end
    end

    always_comb begin
        o_next.scl_out  = n_scl;
        o_next.sda_out  = n_sda;
        o_next.busy_res = (n_cmd != CMD_IDLE);
        o_next.done_res = n_done;
        o_next.rx_byte  = n_rx;
        o_next.ack_in   = n_ack_seen;
    end

    a_idle_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_IDLE) |-> (r_phase == 5'd0))
        else $error("phase counter not cleared while idle");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub != 2'd3)
        else $error("sub-phase counter out of range");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_done) |-> !o_next.busy_res)
        else $error("done raised while still busy");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != CMD_IDLE) |-> (r_phase < seq_len(r_cmd)))
        else $error("phase counter beyond command length");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_cmd) && $stable(r_phase) && $stable(r_scl) && $stable(r_sda)))
        else $error("sequencer moved without a word");

endmodule
